[design/mi4_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the 4x4 matrix inverse
package mi4_pkg;

    localparam int N_ELEM      = 16;
    localparam int POS_W       = 4;
    localparam int QUEUE_DEPTH = 4;

    typedef logic [POS_W-1:0] t_pos;

    localparam t_pos LAST_POS = t_pos'(N_ELEM - 1);

    typedef struct packed {
        t_pos idx;
        logic last;
    } t_tag;

    typedef struct packed {
        t_pos position;
        logic singular;
        logic last;
    } t_res;

endpackage

[design/mi4_front.sv]
`timescale 1ns / 1ps
// input side: accepts elements and tags each with its slot in the matrix
module mi4_front #(
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [ELEMENT_WIDTH-1:0] i_element,
    output logic                     o_full,
    input  logic                     i_q_full,
    output logic                     o_q_push,
    output logic [ELEMENT_WIDTH-1:0] o_q_elem,
    output mi4_pkg::t_tag            o_q_tag
);

    mi4_pkg::t_pos r_load_count;
    mi4_pkg::t_pos n_load_count;

    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;
    assign o_q_elem = i_element;

    always_comb begin
        o_q_tag.idx  = r_load_count;
        o_q_tag.last = (r_load_count == mi4_pkg::LAST_POS);
        n_load_count = o_q_push ? r_load_count + 1'b1 : r_load_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count <= '0;
        end else begin
            r_load_count <= n_load_count;
        end
    end

endmodule

[design/mi4_queue.sv]
`timescale 1ns / 1ps
// short request queue between the front and the back
module mi4_queue #(
    parameter int DATA_W = 37
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    localparam int AW = $clog2(mi4_pkg::QUEUE_DEPTH);

    logic [DATA_W-1:0] r_mem [mi4_pkg::QUEUE_DEPTH];
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     r_rd;
    logic [AW:0]       r_cnt;
    logic              wr_en;
    logic              rd_en;

    assign o_full  = (r_cnt == (AW+1)'(mi4_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[design/mi4_div.sv]
`timescale 1ns / 1ps
// radix-2 restoring divider, one quotient bit per cycle, with overflow flag
module mi4_div #(
    parameter int QW   = 32,
    parameter int NW   = 130,
    parameter int DENW = 130
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [NW-1:0]   i_num,
    input  logic [DENW-1:0] i_den,
    output logic            o_busy,
    output logic            o_done,
    output logic [QW-1:0]   o_quot,
    output logic            o_ovf
);

    localparam int RW   = DENW + 1;
    localparam int CMPW = NW + DENW + QW;
    localparam int CNTW = $clog2(QW + 1);

    logic [RW-1:0]   r_rem;
    logic [DENW-1:0] r_den;
    logic [QW-1:0]   r_low;
    logic [QW-1:0]   r_q;
    logic            r_ovf;
    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [RW-1:0]   shifted;
    logic [RW-1:0]   diff;
    logic            ge;
    logic            ovf_now;

    always_comb begin
        shifted = {r_rem[RW-2:0], r_low[QW-1]};
        ge      = (shifted >= RW'(r_den));
        diff    = shifted - RW'(r_den);
        ovf_now = (CMPW'(i_num) >= (CMPW'(i_den) << QW));
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_ovf  = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= RW'(i_num >> QW);
            r_low <= i_num[QW-1:0];
            r_den <= i_den;
            r_ovf <= ovf_now;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff : shifted;
            r_q   <= {r_q[QW-2:0], ge};
            r_low <= r_low << 1;
        end
    end

endmodule

[design/mi4_back.sv]
`timescale 1ns / 1ps
// back end: matrix store, cofactor and determinant sequencer, scaling and result register
module mi4_back #(
    parameter int ELEMENT_WIDTH = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_empty,
    output logic                     o_q_pop,
    input  logic [ELEMENT_WIDTH-1:0] i_q_elem,
    input  mi4_pkg::t_tag            i_q_tag,
    output logic                     o_empty,
    input  logic                     i_pop,
    output logic [ELEMENT_WIDTH-1:0] o_value,
    output mi4_pkg::t_res            o_res
);

    localparam int W      = ELEMENT_WIDTH;
    localparam int SHL    = 2 * FRACTION_BITS + 1;
    localparam int TW     = 2 * W + 1;
    localparam int CW     = 3 * W + 1;
    localparam int DW     = 4 * W + 2;
    localparam int PW     = 2 * W + 1;
    localparam int NCH_T  = (TW + W - 1) / W;
    localparam int NCH_C  = (CW + W - 1) / W;
    localparam int XW     = NCH_C * W;
    localparam int CHW    = $clog2(NCH_C);
    localparam int NW     = (3 * W + SHL > 4 * W + 1) ? 3 * W + SHL + 1 : 4 * W + 2;
    localparam int DENW   = 4 * W + 2;
    localparam logic [W-1:0] SAT_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] SAT_POS = {1'b0, {(W-1){1'b1}}};
    localparam mi4_pkg::t_pos DET_LAST = mi4_pkg::t_pos'(3);
    localparam logic [1:0]    TERM_LAST = 2'd2;

    typedef enum logic [7:0] {
        S_LOAD   = 8'b0000_0001,
        S_READ   = 8'b0000_0010,
        S_MUL    = 8'b0000_0100,
        S_ACC    = 8'b0000_1000,
        S_CHECK  = 8'b0001_0000,
        S_DSTART = 8'b0010_0000,
        S_DWAIT  = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } t_state;

    typedef enum logic [1:0] {
        PH_T0  = 2'd0,
        PH_T1  = 2'd1,
        PH_CO  = 2'd2,
        PH_DET = 2'd3
    } t_phase;

    t_state               r_state;
    mi4_pkg::t_pos        r_k;
    logic [1:0]           r_i;
    t_phase               r_ph;
    logic [CHW-1:0]       r_ch;
    logic                 r_sing;
    logic                 r_out_valid;

    logic [W-1:0]         r_mem [mi4_pkg::N_ELEM];
    logic signed [W-1:0]  r_rd_a;
    logic signed [W-1:0]  r_rd_b;
    logic signed [PW-1:0] r_prod;
    logic signed [TW-1:0] r_t;
    logic signed [DW-1:0] r_acc;
    logic signed [CW-1:0] r_cof [mi4_pkg::N_ELEM];
    logic [DW-1:0]        r_dabs;
    logic                 r_dneg;
    logic                 r_cneg;
    logic [W-1:0]         r_res_val;
    logic [W-1:0]         r_out_val;
    mi4_pkg::t_res        r_out_res;

    logic [1:0]           row0, row1, row2;
    logic [1:0]           col_i, col1, col2;
    mi4_pkg::t_pos        addr_a;
    mi4_pkg::t_pos        addr_b;
    logic signed [XW-1:0] xs;
    logic [W-1:0]         chunk;
    logic [CHW-1:0]       ch_last;
    logic                 chunk_top;
    logic signed [W:0]    cm;
    logic signed [DW-1:0] prod_sh;
    logic signed [DW-1:0] base;
    logic signed [DW-1:0] acc_sum;
    logic                 acc_sub;
    logic                 first_chunk;
    logic [DW-1:0]        dabs_c;
    logic signed [CW-1:0] cof_cur;
    logic [CW-1:0]        cabs;
    logic [NW-1:0]        num;
    logic [DENW-1:0]      den;
    logic                 out_free;
    logic [W-1:0]         sat_val;

    logic                 div_start;
    logic                 div_busy;
    logic                 div_done;
    logic [W-1:0]         div_quot;
    logic                 div_ovf;

    function automatic logic [1:0] skip_idx(input logic [1:0] drop, input logic [1:0] j);
        return (j < drop) ? j : j + 2'd1;
    endfunction

    function automatic logic [1:0] next3(input logic [1:0] j);
        return (j == TERM_LAST) ? 2'd0 : j + 2'd1;
    endfunction

    // minor drops row c and column r of cofactor (r, c)
    always_comb begin
        row0  = skip_idx(r_k[1:0], 2'd0);
        row1  = skip_idx(r_k[1:0], 2'd1);
        row2  = skip_idx(r_k[1:0], 2'd2);
        col_i = skip_idx(r_k[3:2], r_i);
        col1  = skip_idx(r_k[3:2], next3(r_i));
        col2  = skip_idx(r_k[3:2], next3(next3(r_i)));
        case (r_ph)
            PH_T0: begin
                addr_a = {row1, col1};
                addr_b = {row2, col2};
            end
            PH_T1: begin
                addr_a = {row1, col2};
                addr_b = {row2, col1};
            end
            PH_CO: begin
                addr_a = {row0, col_i};
                addr_b = {row0, col_i};
            end
            PH_DET: begin
                addr_a = {2'd0, r_k[1:0]};
                addr_b = {2'd0, r_k[1:0]};
            end
            default: begin
                addr_a = '0;
                addr_b = '0;
            end
        endcase
    end

    always_comb begin
        case (r_ph)
            PH_CO: begin
                xs      = XW'(r_t);
                ch_last = CHW'(NCH_T - 1);
            end
            PH_DET: begin
                xs      = XW'(r_cof[{r_k[1:0], 2'b00}]);
                ch_last = CHW'(NCH_C - 1);
            end
            default: begin
                xs      = XW'(r_rd_b);
                ch_last = '0;
            end
        endcase
        chunk     = xs[r_ch*W +: W];
        chunk_top = (r_ch == ch_last);
        cm        = $signed({chunk_top && chunk[W-1], chunk});
    end

    always_comb begin
        prod_sh = DW'(r_prod) << (r_ch * W);
        case (r_ph)
            PH_CO:   first_chunk = (r_i == 2'd0) && (r_ch == '0);
            PH_DET:  first_chunk = (r_k == '0) && (r_ch == '0);
            default: first_chunk = 1'b1;
        endcase
        case (r_ph)
            PH_T0:   base = '0;
            PH_T1:   base = DW'(r_t);
            default: base = first_chunk ? '0 : r_acc;
        endcase
        acc_sub = (r_ph == PH_T1) || ((r_ph == PH_CO) && (r_k[2] ^ r_k[0]));
        acc_sum = acc_sub ? base - prod_sh : base + prod_sh;
    end

    always_comb begin
        dabs_c  = r_acc[DW-1] ? DW'(-r_acc) : DW'(r_acc);
        cof_cur = r_cof[r_k];
        cabs    = cof_cur[CW-1] ? CW'(-cof_cur) : CW'(cof_cur);
        num     = (NW'(cabs) << SHL) + NW'(r_dabs);
        den     = DENW'({r_dabs, 1'b0});
    end

    always_comb begin
        if (r_cneg ^ r_dneg) begin
            if (div_ovf || (div_quot[W-1] && (|div_quot[W-2:0]))) begin
                sat_val = SAT_NEG;
            end else begin
                sat_val = -div_quot;
            end
        end else begin
            if (div_ovf || div_quot[W-1]) begin
                sat_val = SAT_POS;
            end else begin
                sat_val = div_quot;
            end
        end
    end

    assign o_q_pop   = (r_state == S_LOAD) && !i_q_empty;
    assign out_free  = !r_out_valid || i_pop;
    assign div_start = (r_state == S_DSTART);
    assign o_empty   = !r_out_valid;
    assign o_value   = r_out_val;
    assign o_res     = r_out_res;

    mi4_div #(
        .QW   (W),
        .NW   (NW),
        .DENW (DENW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_ovf   (div_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_k         <= '0;
            r_i         <= '0;
            r_ph        <= PH_T0;
            r_ch        <= '0;
            r_sing      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid && !((r_state == S_EMIT) && out_free)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (o_q_pop && i_q_tag.last) begin
                        r_state <= S_READ;
                        r_k     <= '0;
                        r_i     <= '0;
                        r_ph    <= PH_T0;
                        r_ch    <= '0;
                    end
                end
                S_READ: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if ((r_ch == ch_last) && (r_ph == PH_DET) && (r_k == DET_LAST)) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_state <= S_READ;
                    end
                    if (r_ch != ch_last) begin
                        r_ch <= r_ch + 1'b1;
                    end else begin
                        r_ch <= '0;
                        case (r_ph)
                            PH_T0: r_ph <= PH_T1;
                            PH_T1: r_ph <= PH_CO;
                            PH_CO: begin
                                if (r_i != TERM_LAST) begin
                                    r_i  <= r_i + 2'd1;
                                    r_ph <= PH_T0;
                                end else begin
                                    r_i  <= '0;
                                    r_k  <= r_k + 1'b1;
                                    r_ph <= (r_k == mi4_pkg::LAST_POS) ? PH_DET : PH_T0;
                                end
                            end
                            PH_DET: begin
                                if (r_k != DET_LAST) begin
                                    r_k <= r_k + 1'b1;
                                end
                            end
                            default: r_ph <= PH_T0;
                        endcase
                    end
                end
                S_CHECK: begin
                    r_k    <= '0;
                    r_sing <= (r_acc == '0);
                    r_state <= (r_acc == '0) ? S_EMIT : S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_sing || (r_k == mi4_pkg::LAST_POS)) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_DSTART;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_mem[i_q_tag.idx] <= i_q_elem;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
        if (r_state == S_MUL) begin
            r_prod <= r_rd_a * cm;
        end
        if (r_state == S_ACC) begin
            if ((r_ph == PH_T0) || (r_ph == PH_T1)) begin
                r_t <= TW'(acc_sum);
            end else begin
                r_acc <= acc_sum;
            end
            if ((r_ph == PH_CO) && (r_ch == ch_last) && (r_i == TERM_LAST)) begin
                r_cof[r_k] <= CW'(acc_sum);
            end
        end
        if (r_state == S_CHECK) begin
            r_dneg <= r_acc[DW-1];
            r_dabs <= dabs_c;
        end
        if (r_state == S_DSTART) begin
            r_cneg <= cof_cur[CW-1];
        end
        if ((r_state == S_DWAIT) && div_done) begin
            r_res_val <= sat_val;
        end
        if ((r_state == S_EMIT) && out_free) begin
            r_out_val          <= r_sing ? '0 : r_res_val;
            r_out_res.position <= r_sing ? '0 : r_k;
            r_out_res.singular <= r_sing;
            r_out_res.last     <= r_sing || (r_k == mi4_pkg::LAST_POS);
        end
    end

`ifndef NO_ASSERTIONS
    a_sing_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.singular) |->
            (r_out_res.last && (r_out_val == '0) && (r_out_res.position == '0)))
        else $error("singular result with wrong payload");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DSTART) |-> !div_busy)
        else $error("divider started while busy");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !div_busy)
        else $error("divider busy while loading");

    a_chunk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (r_ch <= ch_last))
        else $error("chunk index beyond operand");
`endif

endmodule

[design/matrix_inverse_4x4.sv]
`timescale 1ns / 1ps
// top level of the 4x4 fixed-point matrix inverse
//
// channel   direction  handshake          payload
// element   in         push / full        i_element
// result    out        empty / pop        o_value, o_position, o_singular, o_last
//
// a matrix of 16 elements loads through a 4-entry queue at one element per cycle
// while full is low; cofactors and determinant use one shared multiplier, each
// chunk product passing through the read, multiply and accumulate states:
// 16 cofactors x 15 products plus 16 for the determinant; each inverse element
// is then a division in the radix-2 divider, one element after another
// reset is synchronous and active low; a stalled result holds the back end in emit,
// and the back end drains the queue only while loading, so full rises once it fills
module matrix_inverse_4x4 #(
    parameter int ELEMENT_WIDTH = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [ELEMENT_WIDTH-1:0] i_element,
    output logic                     empty,
    input  logic                     pop,
    output logic [ELEMENT_WIDTH-1:0] o_value,
    output logic [3:0]               o_position,
    output logic                     o_singular,
    output logic                     o_last
);

    localparam int QDW = $bits(mi4_pkg::t_tag) + ELEMENT_WIDTH;

    logic                     q_push;
    logic                     q_full;
    logic                     q_pop;
    logic                     q_empty;
    logic [ELEMENT_WIDTH-1:0] f_elem;
    mi4_pkg::t_tag            f_tag;
    logic [QDW-1:0]           q_rd_data;
    logic [ELEMENT_WIDTH-1:0] b_elem;
    mi4_pkg::t_tag            b_tag;
    mi4_pkg::t_res            res;

    assign {b_tag, b_elem} = q_rd_data;
    assign o_position      = res.position;
    assign o_singular      = res.singular;
    assign o_last          = res.last;

    mi4_front #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_element (i_element),
        .o_full    (full),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_elem  (f_elem),
        .o_q_tag   (f_tag)
    );

    mi4_queue #(
        .DATA_W (QDW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_tag, f_elem}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_empty (q_empty)
    );

    mi4_back #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_q_elem  (b_elem),
        .i_q_tag   (b_tag),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_value   (o_value),
        .o_res     (res)
    );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// testbench of the 4x4 matrix inverse: directed and random matrices checked per result
module testbench;

    typedef logic signed [271:0] t_wide;
    typedef logic [31:0] t_mat [mi4_pkg::N_ELEM];

    typedef struct {
        logic [31:0]   value;
        mi4_pkg::t_res res;
    } t_inverse_elem;

    class inverse_scoreboard;
        t_inverse_elem pending[$];
        logic [31:0]   elems[mi4_pkg::N_ELEM];
        int            load_slot;
        int            errors;

        function new();
            load_slot = 0;
            errors    = 0;
        endfunction

        function t_wide elem_at(int r, int c);
            return t_wide'($signed(elems[r * 4 + c]));
        endfunction

        // determinant of the 3x3 minor without row sr and column sc
        function t_wide minor_det(int sr, int sc);
            int    rows[3];
            int    cols[3];
            int    n;
            int    i;
            t_wide acc;
            n = 0;
            for (i = 0; i < 4; i++) if (i != sr) begin rows[n] = i; n++; end
            n = 0;
            for (i = 0; i < 4; i++) if (i != sc) begin cols[n] = i; n++; end
            acc = 0;
            for (i = 0; i < 3; i++) begin
                acc += elem_at(rows[0], cols[i]) *
                    (elem_at(rows[1], cols[(i + 1) % 3]) * elem_at(rows[2], cols[(i + 2) % 3]) -
                     elem_at(rows[1], cols[(i + 2) % 3]) * elem_at(rows[2], cols[(i + 1) % 3]));
            end
            return acc;
        endfunction

        function void predict_inverse();
            t_wide         cof[mi4_pkg::N_ELEM];
            t_wide         det;
            t_wide         dabs;
            t_wide         num;
            logic [271:0]  quo;
            logic          neg;
            t_inverse_elem e;
            int            k;
            for (k = 0; k < mi4_pkg::N_ELEM; k++) begin
                cof[k] = minor_det(k % 4, k / 4);
                if (((k / 4) + (k % 4)) % 2 == 1) cof[k] = -cof[k];
            end
            det = 0;
            for (k = 0; k < 4; k++) det += elem_at(0, k) * cof[k * 4];
            if (det == 0) begin
                e.value        = '0;
                e.res.position = '0;
                e.res.singular = 1'b1;
                e.res.last     = 1'b1;
                pending.push_back(e);
                return;
            end
            dabs = (det < 0) ? -det : det;
            for (k = 0; k < mi4_pkg::N_ELEM; k++) begin
                neg = (cof[k] < 0) != (det < 0);
                num = (cof[k] < 0) ? -cof[k] : cof[k];
                quo = ((num <<< 33) + dabs) / (dabs <<< 1);
                if (neg) begin
                    if (quo > 272'h8000_0000) quo = 272'h8000_0000;
                    e.value = -quo[31:0];
                end else begin
                    if (quo > 272'h7fff_ffff) quo = 272'h7fff_ffff;
                    e.value = quo[31:0];
                end
                e.res.position = mi4_pkg::t_pos'(k);
                e.res.singular = 1'b0;
                e.res.last     = (mi4_pkg::t_pos'(k) == mi4_pkg::LAST_POS);
                pending.push_back(e);
            end
        endfunction

        function void note_element(logic [31:0] x);
            elems[load_slot] = x;
            if (load_slot == mi4_pkg::N_ELEM - 1) begin
                load_slot = 0;
                predict_inverse();
            end else begin
                load_slot++;
            end
        endfunction

        function void check_result(logic [31:0] v, mi4_pkg::t_pos p, logic s, logic l);
            t_inverse_elem e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result value %h position %0d", $time, v, p);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (v !== e.value) begin
                $display("%0t: value expected %h actual %h", $time, e.value, v);
                errors++;
            end
            if (p !== e.res.position) begin
                $display("%0t: position expected %0d actual %0d", $time, e.res.position, p);
                errors++;
            end
            if (s !== e.res.singular) begin
                $display("%0t: singular expected %b actual %b", $time, e.res.singular, s);
                errors++;
            end
            if (l !== e.res.last) begin
                $display("%0t: last expected %b actual %b", $time, e.res.last, l);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [31:0] i_element;
    logic        empty;
    logic        pop;
    logic [31:0] o_value;
    logic [3:0]  o_position;
    logic        o_singular;
    logic        o_last;

    inverse_scoreboard sb;
    bit                stimulus_done;
    int                results_seen;

    matrix_inverse_4x4 u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_element  (i_element),
        .empty      (empty),
        .pop        (pop),
        .o_value    (o_value),
        .o_position (o_position),
        .o_singular (o_singular),
        .o_last     (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic send_matrix(input t_mat a);
        int gap;
        for (int k = 0; k < mi4_pkg::N_ELEM; k++) begin
            gap = $urandom_range(0, 16);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            push      <= 1'b1;
            i_element <= a[k];
            do @(posedge i_clk); while (full);
            sb.note_element(a[k]);
        end
    endtask

    task automatic random_matrix(output t_mat a);
        int mode;
        mode = $urandom_range(0, 3);
        for (int k = 0; k < mi4_pkg::N_ELEM; k++) begin
            case (mode)
                0: a[k] = $urandom();
                1: a[k] = 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
                default: a[k] = 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            endcase
        end
        // rank-deficient: one row repeats another
        if (mode == 3) begin
            for (int c = 0; c < 4; c++) a[12 + c] = a[4 * $urandom_range(0, 0) + c];
        end
    endtask

    initial begin
        t_mat a;
        sb            = new();
        stimulus_done = 1'b0;
        i_rst_n   <= 1'b0;
        push      <= 1'b0;
        i_element <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity
        for (int k = 0; k < mi4_pkg::N_ELEM; k++) a[k] = (k % 5 == 0) ? 32'h0001_0000 : 32'h0;
        send_matrix(a);
        // tiny diagonal with a negative entry: both saturation limits
        for (int k = 0; k < mi4_pkg::N_ELEM; k++) a[k] = '0;
        a[0] = 32'h1; a[5] = 32'h1; a[10] = 32'hffff_ffff; a[15] = 32'h1;
        send_matrix(a);
        // extreme values, equal rows: singular
        for (int k = 0; k < mi4_pkg::N_ELEM; k++) begin
            a[k] = (k % 2 == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        send_matrix(a);

        for (int n = 0; n < 23; n++) begin
            random_matrix(a);
            send_matrix(a);
        end
        push          <= 1'b0;
        stimulus_done = 1'b1;
    end

    initial begin
        int w;
        pop          <= 1'b0;
        results_seen = 0;
        @(posedge i_rst_n);
        forever begin
            w = $urandom_range(0, 16);
            if ($urandom_range(0, 3) == 0) w = 0;
            // long hold-off so the input side fills and stalls
            if (results_seen == 20) w = 4000;
            if (w > 0) begin
                pop <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            sb.check_result(o_value, o_position, o_singular, o_last);
            results_seen++;
        end
    end

    initial begin
        wait (stimulus_done);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
